// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RCF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rcf_pkg.sv =====
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared constants and types of the RC4 / CRC-16 boot image framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcf_pkg;

    localparam int BLOCK_BYTES = 4096;
    localparam int KEY_BYTES   = 16;

    localparam int FILL_W      = $clog2(BLOCK_BYTES);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BLOCK_BYTES - 1);
    localparam logic [FILL_W-1:0] PAD_FROM  = FILL_W'(BLOCK_BYTES - 2);

    localparam int KEY_W       = 64;
    localparam int KEY_IDX_W   = 4;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_LAST = KEY_IDX_W'(KEY_BYTES - 1);

    localparam int SBOX_DEPTH  = 256;
    localparam int SBOX_AW     = 8;
    localparam logic [SBOX_AW-1:0] SBOX_LAST = SBOX_AW'(SBOX_DEPTH - 1);

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hffff;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_END   = 2'd2,
        CMD_NONE  = 2'd3
    } command_t;

    typedef enum logic {
        CFG_KEY_LOW  = 1'b0,
        CFG_KEY_HIGH = 1'b1
    } cfg_index_t;

    // framer -> RC4 engine
    typedef struct packed {
        logic sched;
        logic gen;
    } rc4_req_t;

    // RC4 engine -> framer
    typedef struct packed {
        logic       sched_done;
        logic       ks_valid;
        logic [7:0] ks;
    } rc4_stat_t;

endpackage

// ===== design/rc4_crc16_boot_image_framer_core.sv =====
// ----------------------------------------------------------------------------
// rc4_crc16_boot_image_framer_core
// Encrypts a boot image with RC4, appends a CRC-16 and marks transfer ends.
// ----------------------------------------------------------------------------
// A start beat loads the RC4 state from the 16-byte key (key_low/key_high)
// and opens an image; it gives no output and keeps in_ready low while the
// S-box memory is filled and the key schedule runs, each key-schedule
// step being two dependent reads and a swap written back through the
// single write port. A data beat yields one cipher byte after the accept,
// the S-box read, swap and keystream read states and the load of the
// output register; the S-box memory port sets the pace. An end beat
// yields the two CRC bytes (high first). When the block is within two
// bytes of full, one or two encrypted pad bytes go first, one after the
// other, and the CRC bytes then follow one per cycle while out_ready
// does not stall the output. A data or end beat before any start gives
// one beat with not_started set. Results sit in an output register, so
// the block works on the next beat while a result waits for out_ready.
// CRC-16 is MSB first, polynomial 0x1021, seed 0xffff, over the ciphertext.
// Key registers are written through cfg_wr_en/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_crc16_boot_image_framer_core
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [rcf_pkg::KEY_W-1:0] cfg_data,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                command,
    input  logic [7:0]                data_byte,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                out_byte,
    output logic                      end_of_transfer,
    output logic                      image_done,
    output logic                      not_started,
    output logic                      last
);

    // framing sequencer
    typedef enum logic [5:0] {
        F_IDLE   = 6'b000001,
        F_KEY    = 6'b000010,
        F_GEN    = 6'b000100,
        F_PUSH   = 6'b001000,
        F_CRC_HI = 6'b010000,
        F_CRC_LO = 6'b100000
    } frame_state_t;

    frame_state_t state_reg, state_next;

    // key registers
    logic [rcf_pkg::KEY_W-1:0] key_low_reg, key_high_reg;

    // image state
    logic                      started_reg, started_next;
    logic                      pad_reg, pad_next;
    logic [rcf_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]               crc_reg, crc_next;
    logic [7:0]                data_reg, data_next;

    // staged result waiting for the output register
    logic [7:0] stage_byte_reg, stage_byte_next;
    logic       stage_eot_reg, stage_eot_next;
    logic       stage_ns_reg, stage_ns_next;
    logic       stage_last_reg, stage_last_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_eot_reg, out_eot_next;
    logic       out_done_reg, out_done_next;
    logic       out_ns_reg, out_ns_next;
    logic       out_last_reg, out_last_next;

    logic       out_free;
    logic [7:0] cipher;
    logic       wrap;

    rcf_pkg::rc4_req_t  rc4_req;
    rcf_pkg::rc4_stat_t rc4_stat;

    rcf_rc4_core u_rc4
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_low  (key_low_reg),
        .key_high (key_high_reg),
        .req      (rc4_req),
        .stat     (rc4_stat)
    );

    // one CRC-16 byte step, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ rcf_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    assign in_ready = (state_reg == F_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign cipher   = pad_reg ? rc4_stat.ks : (data_reg ^ rc4_stat.ks);
    assign wrap     = (fill_reg == rcf_pkg::FILL_LAST);

    always_comb
    begin
        state_next      = state_reg;
        started_next    = started_reg;
        pad_next        = pad_reg;
        fill_next       = fill_reg;
        crc_next        = crc_reg;
        data_next       = data_reg;
        stage_byte_next = stage_byte_reg;
        stage_eot_next  = stage_eot_reg;
        stage_ns_next   = stage_ns_reg;
        stage_last_next = stage_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_eot_next    = out_eot_reg;
        out_done_next   = out_done_reg;
        out_ns_next     = out_ns_reg;
        out_last_next   = out_last_reg;
        rc4_req         = '0;

        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (rcf_pkg::command_t'(command))
                        rcf_pkg::CMD_START:
                        begin
                            rc4_req.sched = 1'b1;
                            crc_next      = rcf_pkg::CRC_INIT;
                            fill_next     = '0;
                            started_next  = 1'b1;
                            state_next    = F_KEY;
                        end
                        rcf_pkg::CMD_DATA:
                        begin
                            pad_next = 1'b0;
                            if (!started_reg)
                            begin
                                // dropped: flag only
                                stage_byte_next = '0;
                                stage_eot_next  = 1'b0;
                                stage_ns_next   = 1'b1;
                                stage_last_next = 1'b1;
                                state_next      = F_PUSH;
                            end
                            else
                            begin
                                data_next   = data_byte;
                                rc4_req.gen = 1'b1;
                                state_next  = F_GEN;
                            end
                        end
                        rcf_pkg::CMD_END:
                        begin
                            if (!started_reg)
                            begin
                                pad_next        = 1'b0;
                                stage_byte_next = '0;
                                stage_eot_next  = 1'b0;
                                stage_ns_next   = 1'b1;
                                stage_last_next = 1'b1;
                                state_next      = F_PUSH;
                            end
                            else if (fill_reg >= rcf_pkg::PAD_FROM)
                            begin
                                // too little room for the CRC: pad out the block
                                pad_next    = 1'b1;
                                rc4_req.gen = 1'b1;
                                state_next  = F_GEN;
                            end
                            else
                            begin
                                state_next = F_CRC_HI;
                            end
                        end
                        rcf_pkg::CMD_NONE:
                        begin
                        end
                    endcase
                end
            end
            F_KEY:
            begin
                if (rc4_stat.sched_done)
                begin
                    state_next = F_IDLE;
                end
            end
            F_GEN:
            begin
                if (rc4_stat.ks_valid)
                begin
                    crc_next        = crc16_step(crc_reg, cipher);
                    fill_next       = wrap ? '0 : fill_reg + 1'b1;
                    stage_byte_next = cipher;
                    stage_eot_next  = wrap;
                    stage_ns_next   = 1'b0;
                    stage_last_next = !pad_reg;
                    state_next      = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = stage_byte_reg;
                    out_eot_next   = stage_eot_reg;
                    out_done_next  = 1'b0;
                    out_ns_next    = stage_ns_reg;
                    out_last_next  = stage_last_reg;
                    if (!pad_reg)
                    begin
                        state_next = F_IDLE;
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = F_CRC_HI;
                    end
                    else
                    begin
                        rc4_req.gen = 1'b1;
                        state_next  = F_GEN;
                    end
                end
            end
            F_CRC_HI:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = crc_reg[15:8];
                    out_eot_next   = 1'b0;
                    out_done_next  = 1'b0;
                    out_ns_next    = 1'b0;
                    out_last_next  = 1'b0;
                    state_next     = F_CRC_LO;
                end
            end
            F_CRC_LO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = crc_reg[7:0];
                    out_eot_next   = 1'b1;
                    out_done_next  = 1'b1;
                    out_ns_next    = 1'b0;
                    out_last_next  = 1'b1;
                    fill_next      = '0;
                    started_next   = 1'b0;
                    state_next     = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            started_reg   <= 1'b0;
            pad_reg       <= 1'b0;
            fill_reg      <= '0;
            crc_reg       <= rcf_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
            key_low_reg   <= '0;
            key_high_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            pad_reg       <= pad_next;
            fill_reg      <= fill_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (rcf_pkg::cfg_index_t'(cfg_index))
                    rcf_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                    rcf_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        data_reg       <= data_next;
        stage_byte_reg <= stage_byte_next;
        stage_eot_reg  <= stage_eot_next;
        stage_ns_reg   <= stage_ns_next;
        stage_last_reg <= stage_last_next;
        out_byte_reg   <= out_byte_next;
        out_eot_reg    <= out_eot_next;
        out_done_reg   <= out_done_next;
        out_ns_reg     <= out_ns_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign end_of_transfer = out_eot_reg;
    assign image_done      = out_done_reg;
    assign not_started     = out_ns_reg;
    assign last            = out_last_reg;

endmodule

// ===== design/rcf_sbox_ram.sv =====
// ----------------------------------------------------------------------------
// rcf_sbox_ram
// 256 x 8 S-box memory, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcf_sbox_ram
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [rcf_pkg::SBOX_AW-1:0] waddr,
    input  logic [7:0]                  wdata,
    input  logic [rcf_pkg::SBOX_AW-1:0] raddr,
    output logic [7:0]                  rdata
);

    logic [7:0] mem [rcf_pkg::SBOX_DEPTH];
    logic [7:0] rdata_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rcf_rc4_core.sv =====
// ----------------------------------------------------------------------------
// rcf_rc4_core
// RC4 sequencer around the S-box memory: fill, key schedule, keystream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcf_rc4_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rcf_pkg::KEY_W-1:0]     key_low,
    input  logic [rcf_pkg::KEY_W-1:0]     key_high,
    input  rcf_pkg::rc4_req_t             req,
    output rcf_pkg::rc4_stat_t            stat
);

    typedef enum logic [8:0] {
        C_IDLE    = 9'b000000001,
        C_FILL    = 9'b000000010,
        C_KS_RD_A = 9'b000000100,
        C_KS_RD_J = 9'b000001000,
        C_KS_WR_A = 9'b000010000,
        C_KS_WR_J = 9'b000100000,
        C_PG_RD_J = 9'b001000000,
        C_PG_WR_I = 9'b010000000,
        C_PG_WR_J = 9'b100000000
    } core_state_t;

    core_state_t state_reg, state_next;

    logic [rcf_pkg::SBOX_AW-1:0]   cnt_reg, cnt_next;
    logic [rcf_pkg::KEY_IDX_W-1:0] kidx_reg, kidx_next;
    logic [7:0] i_reg, i_next;
    logic [7:0] j_reg, j_next;
    logic [7:0] si_reg, si_next;
    logic [7:0] sj_reg, sj_next;
    logic [7:0] t_reg, t_next;

    logic                        ram_we;
    logic [rcf_pkg::SBOX_AW-1:0] ram_waddr;
    logic [7:0]                  ram_wdata;
    logic [rcf_pkg::SBOX_AW-1:0] ram_raddr;
    logic [7:0]                  ram_rdata;

    logic [2*rcf_pkg::KEY_W-1:0] key_bus;
    logic [7:0]                  key_b;
    logic [7:0]                  j_ks;
    logic [7:0]                  j_pg;
    logic [7:0]                  t_sum;
    logic [7:0]                  ks_fwd;

    rcf_sbox_ram u_sbox
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign key_bus = {key_high, key_low};
    assign key_b   = key_bus[{kidx_reg, 3'b000} +: 8];
    assign j_ks    = j_reg + ram_rdata + key_b;
    assign j_pg    = j_reg + ram_rdata;
    assign t_sum   = si_reg + ram_rdata;

    // S[t] was read alongside the S[i] write; patch in the swapped values
    assign ks_fwd  = (t_reg == j_reg) ? si_reg :
                     (t_reg == i_reg) ? sj_reg : ram_rdata;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        kidx_next  = kidx_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        si_next    = si_reg;
        sj_next    = sj_reg;
        t_next     = t_reg;
        ram_we     = 1'b0;
        ram_waddr  = cnt_reg;
        ram_wdata  = cnt_reg;
        ram_raddr  = cnt_reg;
        stat       = '0;

        unique case (state_reg)
            C_IDLE:
            begin
                if (req.sched)
                begin
                    cnt_next   = '0;
                    state_next = C_FILL;
                end
                else if (req.gen)
                begin
                    ram_raddr  = i_reg + 8'd1;
                    i_next     = i_reg + 8'd1;
                    state_next = C_PG_RD_J;
                end
            end
            C_FILL:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == rcf_pkg::SBOX_LAST)
                begin
                    j_next     = '0;
                    kidx_next  = '0;
                    state_next = C_KS_RD_A;
                end
            end
            C_KS_RD_A:
            begin
                state_next = C_KS_RD_J;
            end
            C_KS_RD_J:
            begin
                si_next    = ram_rdata;
                j_next     = j_ks;
                ram_raddr  = j_ks;
                state_next = C_KS_WR_A;
            end
            C_KS_WR_A:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                state_next = C_KS_WR_J;
            end
            C_KS_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
                cnt_next  = cnt_reg + 1'b1;
                kidx_next = (kidx_reg == rcf_pkg::KEY_IDX_LAST) ? '0 : kidx_reg + 1'b1;
                if (cnt_reg == rcf_pkg::SBOX_LAST)
                begin
                    i_next          = '0;
                    j_next          = '0;
                    stat.sched_done = 1'b1;
                    state_next      = C_IDLE;
                end
                else
                begin
                    state_next = C_KS_RD_A;
                end
            end
            C_PG_RD_J:
            begin
                si_next    = ram_rdata;
                j_next     = j_pg;
                ram_raddr  = j_pg;
                state_next = C_PG_WR_I;
            end
            C_PG_WR_I:
            begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg;
                ram_wdata  = ram_rdata;
                sj_next    = ram_rdata;
                t_next     = t_sum;
                ram_raddr  = t_sum;
                state_next = C_PG_WR_J;
            end
            C_PG_WR_J:
            begin
                ram_we        = 1'b1;
                ram_waddr     = j_reg;
                ram_wdata     = si_reg;
                stat.ks_valid = 1'b1;
                stat.ks       = ks_fwd;
                state_next    = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            kidx_reg  <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            kidx_reg  <= kidx_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg <= si_next;
        sj_reg <= sj_next;
        t_reg  <= t_next;
    end

endmodule

// ===== design/rcf_checker.sv =====
// ----------------------------------------------------------------------------
// rcf_checker
// Port-level checks on the framer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rcf_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [1:0]                command,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [7:0]                out_byte,
    input logic                      end_of_transfer,
    input logic                      image_done,
    input logic                      not_started,
    input logic                      last
);

    logic in_beat;
    logic out_hold;

    assign in_beat  = in_valid && in_ready;
    assign out_hold = out_valid && !out_ready;

    // a stalled result beat keeps its payload
    `RCF_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_byte) && $stable(last), "output beat changed while stalled")

    // key schedule holds off the input after a start beat
    `RCF_ASSERT_NEXT(a_start_busy, in_beat && command == rcf_pkg::CMD_START, !in_ready, "input ready right after start")

    // the unused command is dropped without going busy
    `RCF_ASSERT_NEXT(a_none_idle, in_beat && command == rcf_pkg::CMD_NONE, in_ready, "unused command made the block busy")

    // image end closes a transfer and the beat's result list
    `RCF_ASSERT_NOW(a_done_eot, out_valid && image_done, end_of_transfer && last && !not_started, "image_done without end_of_transfer and last")

endmodule

bind rc4_crc16_boot_image_framer_core rcf_checker u_rcf_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .end_of_transfer (end_of_transfer),
    .image_done      (image_done),
    .not_started     (not_started),
    .last            (last)
);
